FILE: rtl/fragment_blend_write_macros.svh
// Assertion macros shared by the fragment blend and write stage.
`ifndef FRAGMENT_BLEND_WRITE_MACROS_SVH
`define FRAGMENT_BLEND_WRITE_MACROS_SVH
`ifndef SYNTHESIS
`define FBW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fragment_blend_write: same-cycle check failed");
`define FBW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fragment_blend_write: next-cycle check failed");
`else
`define FBW_ASSERT_IMP(label, clk, rst, ante, cons)
`define FBW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/fbw_pkg.sv
// Types, constants and color arithmetic of the fragment blend and write stage.
package fbw_pkg;

   localparam int FB_WIDTH    = 256;
   localparam int FB_HEIGHT   = 256;
   localparam int PIXEL_COUNT = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_DONE    = 2'd0,
      OUT_SCISSOR = 2'd1,
      OUT_OUTSIDE = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      FAC_ZERO         = 3'd0,
      FAC_ONE          = 3'd1,
      FAC_SRC_ALPHA    = 3'd2,
      FAC_INV_SRC_ALPHA = 3'd3,
      FAC_DST_ALPHA    = 3'd4,
      FAC_INV_DST_ALPHA = 3'd5,
      FAC_SRC_COLOR    = 3'd6,
      FAC_DST_COLOR    = 3'd7
   } factor_type;

   typedef enum logic [3:0] {
      REG_BLEND_ENABLE   = 4'd0,
      REG_SOURCE_FACTOR  = 4'd1,
      REG_DEST_FACTOR    = 4'd2,
      REG_SCISSOR_ENABLE = 4'd3,
      REG_SCISSOR_LEFT   = 4'd4,
      REG_SCISSOR_TOP    = 4'd5,
      REG_SCISSOR_WIDTH  = 4'd6,
      REG_SCISSOR_HEIGHT = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_WRITE
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      outcome_type         outcome;
      logic [ADDR_W-1:0]   addr;
      logic [31:0]         src;
   } item_type;

   function automatic logic [7:0] factor_value(factor_type code, logic [7:0] s_c,
                                               logic [7:0] s_a, logic [7:0] d_c,
                                               logic [7:0] d_a);
      logic [7:0] f;
      case (code)
         FAC_ZERO:          f = 8'd0;
         FAC_ONE:           f = 8'd255;
         FAC_SRC_ALPHA:     f = s_a;
         FAC_INV_SRC_ALPHA: f = 8'd255 - s_a;
         FAC_DST_ALPHA:     f = d_a;
         FAC_INV_DST_ALPHA: f = 8'd255 - d_a;
         FAC_SRC_COLOR:     f = s_c;
         FAC_DST_COLOR:     f = d_c;
         default:           f = 8'd255;
      endcase
      return f;
   endfunction

   // Division by 255 with saturation; exact for every sum below 255 * 256.
   function automatic logic [7:0] div255_sat(logic [16:0] p);
      logic [15:0] t;
      t = p[15:0] + {8'd0, p[15:8]} + 16'd1;
      if (p >= 17'd65280) begin
         return 8'hFF;
      end
      return t[15:8];
   endfunction

endpackage

FILE: rtl/fbw_req_if.sv
// Request channel: write or read command with position and fragment color.
interface fbw_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [7:0]         red_in;
   logic [7:0]         green_in;
   logic [7:0]         blue_in;
   logic [7:0]         alpha_in;

   modport source (output valid, command, pos_x, pos_y, red_in, green_in, blue_in,
                   alpha_in, input ready);
   modport sink (input valid, command, pos_x, pos_y, red_in, green_in, blue_in,
                 alpha_in, output ready);
endinterface

FILE: rtl/fbw_rsp_if.sv
// Response channel: outcome code and the stored pixel color.
interface fbw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;

   modport source (output valid, outcome, red_out, green_out, blue_out, alpha_out,
                   input ready);
   modport sink (input valid, outcome, red_out, green_out, blue_out, alpha_out,
                 output ready);
endinterface

FILE: rtl/fbw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fbw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fragment_blend_write.sv
// Top level of the fragment blend and write stage with its local frame store.
//
// After reset the block clears its FB_WIDTH x FB_HEIGHT frame store one pixel
// per cycle and accepts no beat until that pass ends; configuration writes are
// taken at any time. Each request beat then goes through a memory read, a
// multiply stage and a write-back stage around the single frame store RAM, and
// a new request is taken only after the previous one has left write-back. A
// finished response waits in an output register, and the next request is
// accepted while it waits; write-back stalls only when that register is still
// full.
module fragment_blend_write import fbw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_wdata,
   fbw_req_if.sink     req_chan,
   fbw_rsp_if.source   rsp_chan
);

`include "fragment_blend_write_macros.svh"

   logic               blend_enable_ff;
   factor_type         source_factor_ff;
   factor_type         dest_factor_ff;
   logic               scissor_enable_ff;
   logic signed [15:0] scissor_left_ff;
   logic signed [15:0] scissor_top_ff;
   logic [14:0]        scissor_width_ff;
   logic [14:0]        scissor_height_ff;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_ff, clear_in;
   item_type          item_ff, item_in;
   logic [3:0][15:0]  prod_s_ff, prod_s_in;
   logic [3:0][15:0]  prod_d_ff, prod_d_in;
   logic [31:0]       dst_ff, dst_in;

   logic              rsp_valid_ff, rsp_valid_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;
   logic [31:0]       rsp_pix_ff, rsp_pix_in;

   logic              accept;
   logic              slot_free;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [31:0]       ram_wr_data;
   logic [31:0]       ram_rd_data;
   logic [31:0]       blended;
   logic [31:0]       new_pix;
   logic              store_write;

   logic signed [16:0] x_ext, y_ext, right_ext, bottom_ext, left_ext, top_ext;
   logic               scissor_fail, outside;
   outcome_type        outcome_new;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_enable_ff   <= 1'b0;
         source_factor_ff  <= FAC_SRC_ALPHA;
         dest_factor_ff    <= FAC_INV_SRC_ALPHA;
         scissor_enable_ff <= 1'b0;
         scissor_left_ff   <= '0;
         scissor_top_ff    <= '0;
         scissor_width_ff  <= '0;
         scissor_height_ff <= '0;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_BLEND_ENABLE:   blend_enable_ff   <= csr_wdata[0];
            REG_SOURCE_FACTOR:  source_factor_ff  <= factor_type'(csr_wdata[2:0]);
            REG_DEST_FACTOR:    dest_factor_ff    <= factor_type'(csr_wdata[2:0]);
            REG_SCISSOR_ENABLE: scissor_enable_ff <= csr_wdata[0];
            REG_SCISSOR_LEFT:   scissor_left_ff   <= $signed(csr_wdata);
            REG_SCISSOR_TOP:    scissor_top_ff    <= $signed(csr_wdata);
            REG_SCISSOR_WIDTH:  scissor_width_ff  <= csr_wdata[14:0];
            REG_SCISSOR_HEIGHT: scissor_height_ff <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Classification of the incoming beat.
   always_comb begin
      x_ext      = {req_chan.pos_x[15], req_chan.pos_x};
      y_ext      = {req_chan.pos_y[15], req_chan.pos_y};
      left_ext   = {scissor_left_ff[15], scissor_left_ff};
      top_ext    = {scissor_top_ff[15], scissor_top_ff};
      right_ext  = left_ext + $signed({2'b00, scissor_width_ff});
      bottom_ext = top_ext + $signed({2'b00, scissor_height_ff});
      scissor_fail = (cmd_type'(req_chan.command) == CMD_WRITE) && scissor_enable_ff &&
                     ((x_ext < left_ext) || (x_ext >= right_ext) ||
                      (y_ext < top_ext) || (y_ext >= bottom_ext));
      outside = req_chan.pos_x[15] || req_chan.pos_y[15] ||
                (req_chan.pos_x[14:0] >= 15'(FB_WIDTH)) ||
                (req_chan.pos_y[14:0] >= 15'(FB_HEIGHT));
      if (scissor_fail) begin
         outcome_new = OUT_SCISSOR;
      end else if (outside) begin
         outcome_new = OUT_OUTSIDE;
      end else begin
         outcome_new = OUT_DONE;
      end
   end

   // Blend of the registered products.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         blended[8*c +: 8] = div255_sat({1'b0, prod_s_ff[c]} + {1'b0, prod_d_ff[c]});
      end
      new_pix = blend_enable_ff ? blended : item_ff.src;
   end

   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign accept      = req_chan.valid && req_chan.ready;
   assign store_write = (state_ff == ST_WRITE) && slot_free &&
                        (item_ff.cmd == CMD_WRITE) && (item_ff.outcome == OUT_DONE);

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      item_in        = item_ff;
      prod_s_in      = prod_s_ff;
      prod_d_in      = prod_d_ff;
      dst_in         = dst_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_pix_in     = rsp_pix_ff;
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
            if (clear_ff == ADDR_W'(PIXEL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               item_in.cmd     = cmd_type'(req_chan.command);
               item_in.outcome = outcome_new;
               item_in.addr    = ADDR_W'(req_chan.pos_y[14:0]) * ADDR_W'(FB_WIDTH) +
                                 ADDR_W'(req_chan.pos_x[14:0]);
               item_in.src     = {req_chan.alpha_in, req_chan.blue_in,
                                  req_chan.green_in, req_chan.red_in};
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            dst_in = ram_rd_data;
            for (int c = 0; c < 4; c++) begin
               prod_s_in[c] = item_ff.src[8*c +: 8] *
                              factor_value(source_factor_ff, item_ff.src[8*c +: 8],
                                           item_ff.src[31:24], ram_rd_data[8*c +: 8],
                                           ram_rd_data[31:24]);
               prod_d_in[c] = ram_rd_data[8*c +: 8] *
                              factor_value(dest_factor_ff, item_ff.src[8*c +: 8],
                                           item_ff.src[31:24], ram_rd_data[8*c +: 8],
                                           ram_rd_data[31:24]);
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = item_ff.outcome;
               if (item_ff.outcome != OUT_DONE) begin
                  rsp_pix_in = '0;
               end else if (item_ff.cmd == CMD_READ) begin
                  rsp_pix_in = dst_ff;
               end else begin
                  rsp_pix_in = new_pix;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      prod_s_ff      <= prod_s_in;
      prod_d_ff      <= prod_d_in;
      dst_ff         <= dst_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_pix_ff     <= rsp_pix_in;
   end

   assign ram_we      = (state_ff == ST_CLEAR) || store_write;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clear_ff : item_ff.addr;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? 32'd0 : new_pix;

   fbw_ram #(
      .WIDTH (32),
      .DEPTH (PIXEL_COUNT)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (item_ff.addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.outcome   = rsp_outcome_ff;
   assign rsp_chan.red_out   = rsp_pix_ff[7:0];
   assign rsp_chan.green_out = rsp_pix_ff[15:8];
   assign rsp_chan.blue_out  = rsp_pix_ff[23:16];
   assign rsp_chan.alpha_out = rsp_pix_ff[31:24];

   `FBW_ASSERT_NXT(a_accept_starts_read, clock, reset, accept, state_ff == ST_READ)
   `FBW_ASSERT_IMP(a_rsp_from_writeback, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_WRITE)
   `FBW_ASSERT_IMP(a_store_only_done_writes, clock, reset, ram_we && (state_ff != ST_CLEAR), (item_ff.cmd == CMD_WRITE) && (item_ff.outcome == OUT_DONE))
   `FBW_ASSERT_IMP(a_reject_zero_color, clock, reset, rsp_valid_ff && (rsp_outcome_ff != OUT_DONE), rsp_pix_ff == 32'd0)

endmodule
